FILE: design/mahs_pkg.sv
// ----------------------------------------------------------------------------
// mahs_pkg: shared definitions for the moving average hysteresis switch
// Field widths, reset values of the threshold registers, register indexes
// and width helpers used by every stage of the pipeline.
// ----------------------------------------------------------------------------
package mahs_pkg;

    // Default window length and sample width
    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int AVG_BITS       = 12;
    localparam int THR_BITS       = 12;
    localparam int CFG_INDEX_BITS = 1;

    // Threshold reset values in millivolts
    localparam logic [THR_BITS-1:0] DARK_THRESHOLD_RST  = THR_BITS'(2200);
    localparam logic [THR_BITS-1:0] LIGHT_THRESHOLD_RST = THR_BITS'(2800);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DARK_THRESHOLD  = 1'b0,
        CFG_LIGHT_THRESHOLD = 1'b1
    } cfg_index_t;

    // Ring slot pointer width, at least one bit
    function automatic int calc_slot_bits(input int window);
        calc_slot_bits = (window > 1) ? $clog2(window) : 1;
    endfunction

    // Running total width: holds window times the largest sample
    function automatic int calc_total_bits(input int window, input int sample_bits);
        calc_total_bits = sample_bits + $clog2(window);
    endfunction

    // Average width: wide enough for a full-scale sample and the result field
    function automatic int calc_quot_bits(input int sample_bits);
        calc_quot_bits = (sample_bits > AVG_BITS) ? sample_bits : AVG_BITS;
    endfunction

endpackage

FILE: design/moving_average_hysteresis_switch_top.sv
// ----------------------------------------------------------------------------
// moving_average_hysteresis_switch_top: moving-average light switch
// Sensor samples pass a three-stage pipeline: ring and running total,
// reciprocal multiply for the average, threshold compare and lamp state.
// ----------------------------------------------------------------------------
// The block takes one sample request per clock cycle while the result side
// keeps up and returns one result per sample, presented once the sample has
// passed the window, divide and result registers. The rate is set by the
// running-total update in the first stage; the divide by the window length
// is a single constant multiply in the second stage, and the lamp hysteresis
// is the loop on the lamp register of the third. Stalls on the result side
// back up through the pipeline registers; idle stages still accept new
// samples. Threshold writes take effect at once and belong to idle periods.
module moving_average_hysteresis_switch_top #(
    parameter int WINDOW      = mahs_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mahs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mahs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mahs_pkg::THR_BITS-1:0]       cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_BITS-1:0]              s_sample_mv,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mahs_pkg::AVG_BITS-1:0]       m_average_mv,
    output logic                                m_average_valid,
    output logic                                m_lamp_on
);
    import mahs_pkg::*;

    localparam int TOTAL_BITS = calc_total_bits(WINDOW, SAMPLE_BITS);
    localparam int QUOT_BITS  = calc_quot_bits(SAMPLE_BITS);

    logic                  win_valid, win_ready;
    logic [TOTAL_BITS-1:0] win_total;
    logic                  win_full;
    logic                  div_valid, div_ready;
    logic [QUOT_BITS-1:0]  div_quot;
    logic                  div_full;

    // Ring and running total
    mahs_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_mv (s_sample_mv),
        .out_valid   (win_valid),
        .out_ready   (win_ready),
        .out_total   (win_total),
        .out_full    (win_full)
    );

    // Average by constant reciprocal
    mahs_divide #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_total  (win_total),
        .in_full   (win_full),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quot  (div_quot),
        .out_full  (div_full)
    );

    // Thresholds, lamp and result register
    mahs_hysteresis #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hysteresis (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (div_valid),
        .in_ready        (div_ready),
        .in_quot         (div_quot),
        .in_full         (div_full),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average_mv    (m_average_mv),
        .m_average_valid (m_average_valid),
        .m_lamp_on       (m_lamp_on)
    );

endmodule

FILE: design/mahs_window.sv
// ----------------------------------------------------------------------------
// mahs_window: sample ring and running total
// Accepts one sample per request, replaces the oldest ring entry once the
// window is full, and keeps the running total and fill flag as the stage
// output toward the divider.
// ----------------------------------------------------------------------------
module mahs_window #(
    parameter int WINDOW      = mahs_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mahs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    input  logic                                                      s_valid,
    output logic                                                      s_ready,
    input  logic [SAMPLE_BITS-1:0]                                    s_sample_mv,
    output logic                                                      out_valid,
    input  logic                                                      out_ready,
    output logic [mahs_pkg::calc_total_bits(WINDOW, SAMPLE_BITS)-1:0] out_total,
    output logic                                                      out_full
);
    import mahs_pkg::*;

    localparam int SLOT_BITS  = calc_slot_bits(WINDOW);
    localparam int TOTAL_BITS = calc_total_bits(WINDOW, SAMPLE_BITS);

    logic [SAMPLE_BITS-1:0] ring [WINDOW];
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic                   full_reg, full_next;
    logic [TOTAL_BITS-1:0]  total_reg, total_next;
    logic                   valid_reg, valid_next;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic                   accept;
    logic                   wrap;

    assign s_ready   = !valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = valid_reg;
    assign out_total = total_reg;
    assign out_full  = full_reg;

    // Drop the oldest sample from the total once the window is full
    always_comb begin
        old_sample = full_reg ? ring[slot_reg] : '0;
        total_next = total_reg - TOTAL_BITS'(old_sample) + TOTAL_BITS'(s_sample_mv);
        wrap       = (slot_reg == SLOT_BITS'(WINDOW - 1));
        slot_next  = wrap ? '0 : slot_reg + SLOT_BITS'(1);
        full_next  = full_reg || wrap;
        valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    // Store the sample in its ring slot
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring[slot_reg] <= s_sample_mv;
        end
    end

    // Advance pointer, total and fill flag on each request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            full_reg  <= 1'b0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                slot_reg  <= slot_next;
                full_reg  <= full_next;
                total_reg <= total_next;
            end
        end
    end

    // The fill flag never clears outside reset
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |=> full_reg)
        else $error("window fill flag cleared");

    // The slot pointer stays inside the ring
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_BITS'(WINDOW - 1))
        else $error("ring slot pointer out of range");

    // Before the first wrap, slot zero means no sample has been taken yet
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (!full_reg && slot_reg == '0) |-> (total_reg == '0))
        else $error("running total nonzero on an empty window");

endmodule

FILE: design/mahs_divide.sv
// ----------------------------------------------------------------------------
// mahs_divide: running total divided by the window length
// Multiplies by a rounded-up reciprocal of the window length and keeps the
// upper bits, which gives the truncated quotient for every possible total.
// ----------------------------------------------------------------------------
module mahs_divide #(
    parameter int WINDOW      = mahs_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = mahs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                      aclk,
    input  logic                                                      aresetn,
    input  logic                                                      in_valid,
    output logic                                                      in_ready,
    input  logic [mahs_pkg::calc_total_bits(WINDOW, SAMPLE_BITS)-1:0] in_total,
    input  logic                                                      in_full,
    output logic                                                      out_valid,
    input  logic                                                      out_ready,
    output logic [mahs_pkg::calc_quot_bits(SAMPLE_BITS)-1:0]          out_quot,
    output logic                                                      out_full
);
    import mahs_pkg::*;

    localparam int TOTAL_BITS = calc_total_bits(WINDOW, SAMPLE_BITS);
    localparam int QUOT_BITS  = calc_quot_bits(SAMPLE_BITS);
    localparam int DIV_SHIFT  = TOTAL_BITS + $clog2(WINDOW);
    localparam int MULT_BITS  = DIV_SHIFT + 1;
    localparam int PROD_BITS  = TOTAL_BITS + MULT_BITS;
    localparam longint unsigned DIV_SCALE = longint'(1) << DIV_SHIFT;
    localparam longint unsigned DIV_MULT  = (DIV_SCALE + WINDOW - 1) / WINDOW;

    logic [PROD_BITS-1:0] product;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic                 full_reg;
    logic                 valid_reg, valid_next;
    logic                 advance;

    assign in_ready  = !valid_reg || out_ready;
    assign advance   = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_quot  = quot_reg;
    assign out_full  = full_reg;

    // Scale by the reciprocal and keep the integer part
    always_comb begin
        product    = PROD_BITS'(in_total) * PROD_BITS'(DIV_MULT);
        quot_next  = QUOT_BITS'(product >> DIV_SHIFT);
        valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    // Hold the quotient for the threshold stage
    always_ff @(posedge aclk) begin
        if (advance) begin
            quot_reg <= quot_next;
            full_reg <= in_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: design/mahs_hysteresis.sv
// ----------------------------------------------------------------------------
// mahs_hysteresis: threshold registers, lamp state and result register
// Compares the average against the dark and light thresholds, switches the
// lamp with hysteresis and holds the result until it is taken.
// ----------------------------------------------------------------------------
module mahs_hysteresis #(
    parameter int SAMPLE_BITS = mahs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             cfg_we,
    input  logic [mahs_pkg::CFG_INDEX_BITS-1:0]              cfg_index,
    input  logic [mahs_pkg::THR_BITS-1:0]                    cfg_wdata,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic [mahs_pkg::calc_quot_bits(SAMPLE_BITS)-1:0] in_quot,
    input  logic                                             in_full,
    output logic                                             m_valid,
    input  logic                                             m_ready,
    output logic [mahs_pkg::AVG_BITS-1:0]                    m_average_mv,
    output logic                                             m_average_valid,
    output logic                                             m_lamp_on
);
    import mahs_pkg::*;

    localparam int QUOT_BITS = calc_quot_bits(SAMPLE_BITS);

    logic [THR_BITS-1:0] dark_reg;
    logic [THR_BITS-1:0] light_reg;
    logic                lamp_reg, lamp_next;
    logic [AVG_BITS-1:0] avg_reg, avg_next;
    logic                avg_valid_reg;
    logic                valid_reg, valid_next;
    logic                advance;

    assign in_ready        = !valid_reg || m_ready;
    assign advance         = in_valid && in_ready;
    assign m_valid         = valid_reg;
    assign m_average_mv    = avg_reg;
    assign m_average_valid = avg_valid_reg;
    assign m_lamp_on       = lamp_reg;

    // Once the window is full, switch on below dark, off above light, hold in between
    always_comb begin
        lamp_next = lamp_reg;
        avg_next  = '0;
        if (in_full) begin
            avg_next = in_quot[AVG_BITS-1:0];
            if (!lamp_reg && in_quot < QUOT_BITS'(dark_reg)) begin
                lamp_next = 1'b1;
            end else if (lamp_reg && in_quot > QUOT_BITS'(light_reg)) begin
                lamp_next = 1'b0;
            end
        end
        valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg  <= DARK_THRESHOLD_RST;
            light_reg <= LIGHT_THRESHOLD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DARK_THRESHOLD:  dark_reg  <= cfg_wdata;
                CFG_LIGHT_THRESHOLD: light_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            avg_reg       <= avg_next;
            avg_valid_reg <= in_full;
        end
    end

    // Lamp state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (advance) begin
                lamp_reg <= lamp_next;
            end
        end
    end

    // The lamp only moves when an average enters the result register
    a_lamp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(lamp_reg))
        else $error("lamp changed without a new average");

endmodule

FILE: tb/moving_average_hysteresis_switch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_hysteresis_switch_top_tb: self-checking bench for the lamp switch
// Sensor samples are driven through a valid/ready channel with random gaps on
// both sides. A cycle-free predictor keeps its own sample history, running
// total and lamp flag, and every result is checked field by field against it.
// Threshold pairs, including the extremes and a crossed pair, are written
// between phases while the block is drained.
// ----------------------------------------------------------------------------
module moving_average_hysteresis_switch_top_tb;

    import mahs_pkg::*;

    localparam int WIN            = WINDOW_DEF;
    localparam int SMP_BITS       = SAMPLE_BITS_DEF;
    localparam int SMP_MAX        = (1 << SMP_BITS) - 1;
    localparam int PIPE_SETTLE    = 6;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [AVG_BITS-1:0] average_mv;
        logic                average_valid;
        logic                lamp_on;
    } lamp_result_t;

    // DUT inputs, all known from time zero
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_we          = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index       = CFG_DARK_THRESHOLD;
    logic [THR_BITS-1:0]       cfg_wdata       = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [SMP_BITS-1:0]       s_sample_mv     = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic [AVG_BITS-1:0]       m_average_mv;
    logic                      m_average_valid;
    logic                      m_lamp_on;

    // Stimulus and scoreboard state
    logic [SMP_BITS-1:0] pending_samples[$];
    lamp_result_t        expected_results[$];
    logic                req_done       = 1'b0;
    int                  send_idle_pct  = 0;
    int                  recv_idle_pct  = 0;
    int                  queued_count   = 0;
    int                  accepted_count = 0;
    int                  checked_count  = 0;
    int                  error_count    = 0;
    int                  stall_cycles   = 0;
    int                  setting_count  = 1;

    // Predictor copy of the block state
    logic [SMP_BITS-1:0] hist_ring[WIN];
    int                  hist_slot      = 0;
    bit                  hist_full      = 1'b0;
    int                  hist_total     = 0;
    bit                  lamp_lit       = 1'b0;
    logic [THR_BITS-1:0] dark_mv        = DARK_THRESHOLD_RST;
    logic [THR_BITS-1:0] light_mv       = LIGHT_THRESHOLD_RST;
    int                  lamp_on_count  = 0;
    int                  lamp_off_count = 0;

    moving_average_hysteresis_switch_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_mv     (s_sample_mv),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_average_mv    (m_average_mv),
        .m_average_valid (m_average_valid),
        .m_lamp_on       (m_lamp_on)
    );

    always #5 aclk = ~aclk;

    // Advance the sample history by one sample and return the lamp result
    function automatic lamp_result_t predict_lamp_result(logic [SMP_BITS-1:0] sample);
        lamp_result_t res;
        int           avg;
        avg = 0;
        if (hist_full) begin
            hist_total -= hist_ring[hist_slot];
        end
        hist_ring[hist_slot] = sample;
        hist_total += sample;
        hist_slot++;
        if (hist_slot >= WIN) begin
            hist_slot = 0;
            hist_full = 1'b1;
        end
        if (hist_full) begin
            avg = hist_total / WIN;
            if (!lamp_lit && avg < dark_mv) begin
                lamp_lit = 1'b1;
                lamp_on_count++;
            end else if (lamp_lit && avg > light_mv) begin
                lamp_lit = 1'b0;
                lamp_off_count++;
            end
        end
        res.average_mv    = AVG_BITS'(avg);
        res.average_valid = hist_full;
        res.lamp_on       = lamp_lit;
        return res;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Drive sample requests and result-side ready at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_done) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_sample_mv <= pending_samples.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Track handshakes, predict accepted samples and check results
    always @(posedge aclk) begin
        lamp_result_t want;
        req_done <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DARK_THRESHOLD:  dark_mv = cfg_wdata;
                    CFG_LIGHT_THRESHOLD: light_mv = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_lamp_result(s_sample_mv));
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                checked_count++;
                if (expected_results.size() == 0) begin
                    report_error("result with no sample outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (m_average_mv !== want.average_mv)
                        report_error($sformatf("result %0d average_mv %0d, want %0d",
                            checked_count, m_average_mv, want.average_mv));
                    if (m_average_valid !== want.average_valid)
                        report_error($sformatf("result %0d average_valid %b, want %b",
                            checked_count, m_average_valid, want.average_valid));
                    if (m_lamp_on !== want.lamp_on)
                        report_error($sformatf("result %0d lamp_on %b, want %b",
                            checked_count, m_lamp_on, want.lamp_on));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // End the run if the channels stop moving
    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("moving_average_hysteresis_switch_top_tb: errors");
        $finish;
    end

    task automatic queue_sample(int mv);
        if (mv < 0) mv = 0;
        if (mv > SMP_MAX) mv = SMP_MAX;
        pending_samples.push_back(SMP_BITS'(mv));
        queued_count++;
    endtask

    task automatic queue_run(int mv, int count);
        repeat (count) queue_sample(mv);
    endtask

    // Hold until every request is taken and every result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (accepted_count != queued_count || expected_results.size() != 0);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    // Write both thresholds on consecutive cycles; called at a falling edge
    task automatic write_thresholds(int dark, int light);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DARK_THRESHOLD;
        cfg_wdata <= THR_BITS'(dark);
        @(negedge aclk);
        cfg_index <= CFG_LIGHT_THRESHOLD;
        cfg_wdata <= THR_BITS'(light);
        @(negedge aclk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Mostly runs that hover around a threshold, plus rail runs and noise
    task automatic queue_random_phase(int n_items);
        int made;
        int kind;
        int level;
        int run_len;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                level   = $urandom_range(1) ? int'(dark_mv) : int'(light_mv);
                level   = level + int'($urandom_range(60)) - 30;
                run_len = $urandom_range(3, 10);
                repeat (run_len) queue_sample(level + int'($urandom_range(6)) - 3);
            end else if (kind < 75) begin
                run_len = $urandom_range(2, 6);
                queue_run($urandom_range(1) ? SMP_MAX : 0, run_len);
            end else begin
                run_len = 1;
                queue_sample($urandom_range(SMP_MAX));
            end
            made += run_len;
        end
    endtask

    initial begin
        int dark;
        for (int i = 0; i < WIN; i++) hist_ring[i] = '0;
        set_idling(20, 48);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill the window with the rails, then walk the default thresholds:
        // equal to dark holds, just below turns on, equal to light holds,
        // just above turns off
        queue_sample(0);
        queue_run(SMP_MAX, 4);
        queue_run(2200, 5);
        queue_run(2199, 5);
        queue_run(2800, 5);
        queue_run(2801, 5);
        wait_drained();

        // Extremes: lamp can never turn on, then can never turn off
        write_thresholds(0, 0);
        queue_random_phase(100);
        wait_drained();
        write_thresholds(SMP_MAX, SMP_MAX);
        queue_random_phase(100);
        wait_drained();

        // Crossed pair toggles freely; widest pair holds forever
        set_idling(48, 20);
        write_thresholds(SMP_MAX, 0);
        queue_random_phase(150);
        wait_drained();
        write_thresholds(0, SMP_MAX);
        queue_random_phase(100);
        wait_drained();

        // Random ordered pairs, with the last two gap-free
        for (int p = 0; p < 3; p++) begin
            if (p == 1) set_idling(0, 0);
            dark = $urandom_range(SMP_MAX);
            write_thresholds(dark, $urandom_range(dark, SMP_MAX));
            queue_random_phase(180);
            wait_drained();
        end

        // Back to the reset pair
        write_thresholds(int'(DARK_THRESHOLD_RST), int'(LIGHT_THRESHOLD_RST));
        queue_random_phase(150);
        wait_drained();

        if (expected_results.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_results.size()));
        $display("run covered %0d samples over %0d threshold pairs, %0d results checked",
            accepted_count, setting_count, checked_count);
        $display("lamp turned on %0d times and off %0d times", lamp_on_count, lamp_off_count);
        if (error_count == 0) begin
            $display("moving_average_hysteresis_switch_top_tb: clean");
        end else begin
            $display("moving_average_hysteresis_switch_top_tb: errors");
        end
        $finish;
    end

endmodule
